>>> design/csu_pkg.sv
package csu_pkg;

    // Result format: signed Q1.15 similarity
    localparam int SIM_W    = 16;
    localparam int FRAC_W   = 15;
    // Magnitude of the root search: covers 0 .. 2^FRAC_W
    localparam int ROOT_W   = FRAC_W + 1;
    // dot^2 is scaled by 2^(2*FRAC_W) before the compare
    localparam int SCALE_SH = 2 * FRAC_W;

    localparam int DEF_MAX_LEN   = 1024;
    localparam int DEF_ELEM_BITS = 16;

    localparam logic signed [SIM_W-1:0] THRESH_RESET = 16'sd29491;
    localparam logic [ROOT_W-1:0]       ROOT_CLAMP   = 16'h7FFF;
    localparam logic [ROOT_W-1:0]       ROOT_ONE     = 16'h8000;

    // Width of an unsigned squared-norm accumulator
    function automatic int norm_width(input int max_len, input int elem_bits);
        return 2 * elem_bits - 1 + $clog2(max_len);
    endfunction

endpackage

>>> design/csu_if.sv
interface csu_in_if #(
    parameter int ELEM_BITS = csu_pkg::DEF_ELEM_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic                        last_elem;

    modport source (output valid, output elem_a, output elem_b, output last_elem,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last_elem,
                    output ready);
endinterface

interface csu_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [csu_pkg::SIM_W-1:0]  similarity;
    logic                              is_match;
    logic                              zero_norm;
    logic                              too_long;

    modport source (output valid, output similarity, output is_match,
                    output zero_norm, output too_long, input ready);
    modport sink   (input valid, input similarity, input is_match,
                    input zero_norm, input too_long, output ready);
endinterface

>>> design/cosine_similarity_unit.sv
// Streaming cosine similarity of two vectors. Element pairs arrive on i_elem
// as signed values; while ready is high the unit takes one pair per clock,
// summing the dot product and both squared norms. A pair with last_elem set
// closes the vector: the unit then drops ready and computes the signed Q1.15
// similarity (truncated toward zero, +1.0 clamped to 32767, exact -1.0 giving
// -32768) in a shared add/shift engine: two serial multiplies, then a test
// and an update step per result bit. Ready returns once the result enters the
// output register. If either norm is zero the result is 0 with zero_norm set
// and the engine is skipped. Pairs past MAX_LEN are dropped and reported by
// too_long. is_match is set when the result is at least the match threshold
// r_threshold, written through i_cfg_we/i_cfg_wdata by the user while idle;
// the block does not enforce this. The result waits in an output register, so
// the next vector may stream in while the previous one is pending on o_result.
module cosine_similarity_unit #(
    parameter int MAX_LEN   = csu_pkg::DEF_MAX_LEN,
    parameter int ELEM_BITS = csu_pkg::DEF_ELEM_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    csu_in_if.sink                           i_elem,
    csu_out_if.source                        o_result,
    input  logic                             i_cfg_we,
    input  logic signed [csu_pkg::SIM_W-1:0] i_cfg_wdata
);

    localparam int NORM_W = csu_pkg::norm_width(MAX_LEN, ELEM_BITS);
    localparam int DOT_W  = NORM_W + 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = 2 * ELEM_BITS;

    typedef enum logic [1:0] {
        S_ACC,
        S_CALC,
        S_EMIT
    } t_top_state;

    t_top_state                       r_state;
    logic signed [DOT_W-1:0]          r_dot;
    logic [NORM_W-1:0]                r_norm_a;
    logic [NORM_W-1:0]                r_norm_b;
    logic [CNT_W-1:0]                 r_count;
    logic                             r_ovf;
    logic                             r_zero;
    logic                             r_start;
    logic [csu_pkg::ROOT_W-1:0]       r_root;
    logic signed [csu_pkg::SIM_W-1:0] r_threshold;

    logic                             r_out_valid;
    logic signed [csu_pkg::SIM_W-1:0] r_out_sim;
    logic                             r_out_match;
    logic                             r_out_zero;
    logic                             r_out_long;

    logic signed [DOT_W-1:0]          n_dot;
    logic [NORM_W-1:0]                n_norm_a;
    logic [NORM_W-1:0]                n_norm_b;
    logic [CNT_W-1:0]                 n_count;
    logic                             n_ovf;

    logic signed [PROD_W-1:0]         w_prod_ab;
    logic signed [PROD_W-1:0]         w_sq_a;
    logic signed [PROD_W-1:0]         w_sq_b;
    logic                             w_accept;
    logic                             w_zero;
    logic                             w_out_free;
    logic [NORM_W-1:0]                w_dot_mag;
    logic                             w_core_done;
    logic [csu_pkg::ROOT_W-1:0]       w_core_root;
    logic signed [csu_pkg::ROOT_W:0]  w_neg_root;
    logic signed [csu_pkg::SIM_W-1:0] w_sim;

    assign i_elem.ready = (r_state == S_ACC);
    assign w_accept     = i_elem.valid && i_elem.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    // Accumulate one pair; a pair past MAX_LEN only raises the overflow flag
    always_comb begin
        w_prod_ab = i_elem.elem_a * i_elem.elem_b;
        w_sq_a    = i_elem.elem_a * i_elem.elem_a;
        w_sq_b    = i_elem.elem_b * i_elem.elem_b;
        n_dot     = r_dot;
        n_norm_a  = r_norm_a;
        n_norm_b  = r_norm_b;
        n_count   = r_count;
        n_ovf     = r_ovf;
        if (r_count >= CNT_W'(MAX_LEN)) begin
            n_ovf = 1'b1;
        end else begin
            n_dot    = r_dot + DOT_W'(w_prod_ab);
            n_norm_a = r_norm_a + NORM_W'($unsigned(w_sq_a));
            n_norm_b = r_norm_b + NORM_W'($unsigned(w_sq_b));
            n_count  = r_count + 1'b1;
        end
        w_zero = (n_norm_a == '0) || (n_norm_b == '0);
    end

    // |dot| never exceeds the largest norm, so it fits NORM_W bits
    assign w_dot_mag = r_dot[DOT_W-1] ? NORM_W'(-r_dot) : NORM_W'(r_dot);

    // Negate one bit wider so that a root of exactly 1.0 lands on -32768
    assign w_neg_root = -$signed({1'b0, r_root});

    // Apply the sign of dot; clamp +1.0 into range
    always_comb begin
        if (r_dot[DOT_W-1]) begin
            w_sim = w_neg_root[csu_pkg::SIM_W-1:0];
        end else if (r_root > csu_pkg::ROOT_CLAMP) begin
            w_sim = $signed(csu_pkg::ROOT_CLAMP);
        end else begin
            w_sim = $signed(r_root);
        end
    end

    csu_ratio_core #(
        .NORM_W (NORM_W)
    ) u_ratio_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_norm_a  (r_norm_a),
        .i_norm_b  (r_norm_b),
        .i_dot_mag (w_dot_mag),
        .o_done    (w_core_done),
        .o_root    (w_core_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_dot       <= '0;
            r_norm_a    <= '0;
            r_norm_b    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_zero      <= 1'b0;
            r_start     <= 1'b0;
            r_root      <= '0;
            r_threshold <= csu_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // Kick the root engine once a closed vector has nonzero norms
            r_start <= w_accept && i_elem.last_elem && !w_zero;

            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end

            // Drop the pending result once the sink takes it, unless a new one replaces it
            if (r_out_valid && o_result.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_ACC: begin
                    if (w_accept) begin
                        r_dot    <= n_dot;
                        r_norm_a <= n_norm_a;
                        r_norm_b <= n_norm_b;
                        r_count  <= n_count;
                        r_ovf    <= n_ovf;
                        if (i_elem.last_elem) begin
                            r_zero <= w_zero;
                            r_root <= '0;
                            if (w_zero) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_CALC;
                            end
                        end
                    end
                end
                S_CALC: begin
                    if (w_core_done) begin
                        r_root  <= w_core_root;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register frees, then clear for the next vector
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sim   <= w_sim;
                        r_out_match <= (w_sim >= r_threshold);
                        r_out_zero  <= r_zero;
                        r_out_long  <= r_ovf;
                        r_dot       <= '0;
                        r_norm_a    <= '0;
                        r_norm_b    <= '0;
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.similarity = r_out_sim;
    assign o_result.is_match   = r_out_match;
    assign o_result.zero_norm  = r_out_zero;
    assign o_result.too_long   = r_out_long;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACC) |-> !i_elem.ready)
        else $error("ready while a vector is being finished");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_sim == '0))
        else $error("nonzero similarity with zero norm");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_done |-> (r_state == S_CALC))
        else $error("root engine finished outside calc state");

endmodule

>>> design/csu_ratio_core.sv
module csu_ratio_core #(
    parameter int NORM_W = csu_pkg::norm_width(csu_pkg::DEF_MAX_LEN, csu_pkg::DEF_ELEM_BITS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NORM_W-1:0]          i_norm_a,
    input  logic [NORM_W-1:0]          i_norm_b,
    input  logic [NORM_W-1:0]          i_dot_mag,
    output logic                       o_done,
    output logic [csu_pkg::ROOT_W-1:0] o_root
);

    // Wide enough for root^2 * na * nb with any 16-bit root candidate
    localparam int BW    = 2 * NORM_W + 2 * csu_pkg::ROOT_W;
    localparam int CNT_W = $clog2(NORM_W);
    localparam int BIT_W = $clog2(csu_pkg::ROOT_W);

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL_P,
        C_MUL_Q,
        C_TEST,
        C_UPD
    } t_core_state;

    t_core_state                r_state;
    logic [BW-1:0]              r_acc;     // product, then root^2 * p
    logic [BW-1:0]              r_mcand;   // multiplicand, then p * 4^bit
    logic [BW-1:0]              r_v;       // holds p, then root * p * 2^(bit+1)
    logic [BW-1:0]              r_q;       // dot^2 * 2^30
    logic [NORM_W-1:0]          r_mplier;
    logic [CNT_W-1:0]           r_cnt;
    logic [BIT_W-1:0]           r_bit;
    logic                       r_keep;
    logic                       r_done;
    logic [csu_pkg::ROOT_W-1:0] r_root;

    logic [BW-1:0] w_opx;
    logic [BW-1:0] w_opy;
    logic [BW-1:0] w_opz;
    logic [BW-1:0] w_sum;

    // Shared three-operand adder: serial multiply, then root search
    always_comb begin
        w_opx = '0;
        w_opy = '0;
        w_opz = '0;
        case (r_state)
            C_MUL_P, C_MUL_Q: begin
                w_opx = r_acc;
                w_opy = r_mplier[0] ? r_mcand : '0;
            end
            C_TEST: begin
                w_opx = r_acc;
                w_opy = r_v;
                w_opz = r_mcand;
            end
            C_UPD: begin
                w_opx = r_v >> 1;
                w_opy = r_keep ? r_mcand : '0;
            end
            default: begin
                w_opx = '0;
            end
        endcase
        w_sum = w_opx + w_opy + w_opz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_root  <= '0;
        end else begin
            r_done <= (r_state == C_UPD) && (r_bit == '0);
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_acc    <= '0;
                        r_mcand  <= BW'(i_norm_a);
                        r_mplier <= i_norm_b;
                        r_cnt    <= '0;
                        r_state  <= C_MUL_P;
                    end
                end
                C_MUL_P: begin
                    if (r_cnt == CNT_W'(NORM_W - 1)) begin
                        // park p in r_v while dot^2 is formed
                        r_v      <= w_sum;
                        r_acc    <= '0;
                        r_mcand  <= BW'(i_dot_mag) << csu_pkg::SCALE_SH;
                        r_mplier <= i_dot_mag;
                        r_cnt    <= '0;
                        r_state  <= C_MUL_Q;
                    end else begin
                        r_acc    <= w_sum;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                C_MUL_Q: begin
                    if (r_cnt == CNT_W'(NORM_W - 1)) begin
                        r_q     <= w_sum;
                        r_acc   <= '0;
                        r_mcand <= r_v << (2 * (csu_pkg::ROOT_W - 1));
                        r_v     <= '0;
                        r_root  <= '0;
                        r_bit   <= BIT_W'(csu_pkg::ROOT_W - 1);
                        r_state <= C_TEST;
                    end else begin
                        r_acc    <= w_sum;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                C_TEST: begin
                    // candidate (root + 2^bit)^2 * p against dot^2 * 2^30
                    r_keep <= (w_sum <= r_q);
                    if (w_sum <= r_q) begin
                        r_acc         <= w_sum;
                        r_root[r_bit] <= 1'b1;
                    end
                    r_state <= C_UPD;
                end
                C_UPD: begin
                    r_v     <= w_sum;
                    r_mcand <= r_mcand >> 2;
                    if (r_bit == '0) begin
                        r_state <= C_IDLE;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= C_TEST;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_root <= csu_pkg::ROOT_ONE))
        else $error("root above unity");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == C_IDLE))
        else $error("start while busy");

endmodule

>>> tb/cosine_similarity_unit_test.sv
// One expected result of a closed vector pair.
typedef struct {
    logic signed [csu_pkg::SIM_W-1:0] similarity;
    logic                             is_match;
    logic                             zero_norm;
    logic                             too_long;
} cos_result_t;

// Tracks the running sums of the vector pair in flight, works out the
// Q1.15 cosine when a pair closes and checks the results that come back.
class similarity_scoreboard;
    int                 max_len;
    int                 threshold;
    longint             dot_acc;
    longint unsigned    norm_a_acc;
    longint unsigned    norm_b_acc;
    int unsigned        pair_count;
    bit                 dropped;
    cos_result_t        pending_results[$];
    int                 errors;
    int                 vectors;
    int                 checked;
    int                 matches_seen;
    int                 zero_seen;
    int                 long_seen;

    function new(int max_len_i);
        max_len   = max_len_i;
        threshold = int'(csu_pkg::THRESH_RESET);
        clear_sums();
    endfunction

    function void clear_sums();
        dot_acc    = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        pair_count = 0;
        dropped    = 1'b0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Largest magnitude m in [0, 2^15] with m*m*na*nb <= dot*dot*2^30,
    // signed like dot, positive side clamped to 32767.
    function int cosine_q15();
        bit [127:0]      norm_prod;
        bit [127:0]      dot_scaled;
        bit [127:0]      trial;
        longint unsigned mag;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        mag        = (dot_acc < 0) ? longint'(-dot_acc) : dot_acc;
        norm_prod  = norm_a_acc;
        norm_prod  = norm_prod * norm_b_acc;
        dot_scaled = mag;
        dot_scaled = dot_scaled * mag;
        dot_scaled = dot_scaled << csu_pkg::SCALE_SH;
        lo = 0;
        hi = 1 << csu_pkg::FRAC_W;
        while (lo < hi) begin
            mid   = (lo + hi + 1) >> 1;
            trial = mid;
            trial = trial * mid;
            trial = trial * norm_prod;
            if (trial <= dot_scaled) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (dot_acc < 0) begin
            return -int'(lo);
        end
        return (lo > 32767) ? 32767 : int'(lo);
    endfunction

    // Call once per accepted input transaction.
    function void note_pair(logic signed [csu_pkg::DEF_ELEM_BITS-1:0] a,
                            logic signed [csu_pkg::DEF_ELEM_BITS-1:0] b,
                            logic last);
        longint      av;
        longint      bv;
        int          sim;
        cos_result_t r;
        if (pair_count >= max_len) begin
            dropped = 1'b1;
        end else begin
            av = a;
            bv = b;
            dot_acc    += av * bv;
            norm_a_acc += longint'(av * av);
            norm_b_acc += longint'(bv * bv);
            pair_count++;
        end
        if (!last) begin
            return;
        end
        if (norm_a_acc == 0 || norm_b_acc == 0) begin
            sim         = 0;
            r.zero_norm = 1'b1;
        end else begin
            sim         = cosine_q15();
            r.zero_norm = 1'b0;
        end
        r.similarity = sim[csu_pkg::SIM_W-1:0];
        r.is_match   = (sim >= threshold);
        r.too_long   = dropped;
        pending_results = {pending_results, r};
        vectors++;
        clear_sums();
    endfunction

    // Call once per accepted output transaction.
    function void check_result(logic signed [csu_pkg::SIM_W-1:0] sim, logic m,
                               logic z, logic l);
        cos_result_t e;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected result: sim=%0d match=%0b zero=%0b long=%0b",
                         sim, m, z, l);
            end
            return;
        end
        e = pending_results.pop_front();
        checked++;
        matches_seen += e.is_match;
        zero_seen    += e.zero_norm;
        long_seen    += e.too_long;
        if (sim !== e.similarity || m !== e.is_match || z !== e.zero_norm ||
            l !== e.too_long) begin
            errors++;
            if (errors <= 10) begin
                $display("result %0d mismatch: expected sim=%0d match=%0b zero=%0b long=%0b,",
                         checked, e.similarity, e.is_match, e.zero_norm, e.too_long);
                $display("    got sim=%0d match=%0b zero=%0b long=%0b", sim, m, z, l);
            end
        end
    endfunction
endclass

module cosine_similarity_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN   = csu_pkg::DEF_MAX_LEN;
    localparam int ELEM_BITS = csu_pkg::DEF_ELEM_BITS;
    // Let the block finish any closing computation.
    localparam int SETTLE_CYCLES = 150;
    // Long receiver hold-off: several vectors' worth of compute time.
    localparam int HOLD_CYCLES   = 600;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_PARALLEL,
        SHAPE_OPPOSED,
        SHAPE_NEAR,
        SHAPE_EXTREME,
        SHAPE_ONE_ZERO,
        SHAPE_TINY
    } vector_shape_e;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic signed [csu_pkg::SIM_W-1:0] cfg_wdata;

    csu_in_if #(.ELEM_BITS(ELEM_BITS)) in_bus ();
    csu_out_if                         out_bus ();

    cosine_similarity_unit #(
        .MAX_LEN  (MAX_LEN),
        .ELEM_BITS(ELEM_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_elem     (in_bus.sink),
        .o_result   (out_bus.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    similarity_scoreboard sb = new(MAX_LEN);

    // The first two flags are shared between the stimulus and the receiver process.
    bit calm;           // no idling on either side
    bit hold_request;   // ask the receiver for one long hold-off
    int pairs_sent;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: end a hung run well past the slowest legal one.
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: check every output transaction at the rising edge, then pick
    // ready for the next cycle at the falling edge. Stall in random bursts,
    // and hold off for a long stretch once when asked.
    initial begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                sb.check_result(out_bus.similarity, out_bus.is_match,
                                out_bus.zero_norm, out_bus.too_long);
            end
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Offer one pair and hold it until accepted. Enter and leave at a falling
    // edge; valid stays high into the next pair unless a gap is inserted.
    task automatic send_pair(input logic signed [ELEM_BITS-1:0] a,
                             input logic signed [ELEM_BITS-1:0] b,
                             input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.elem_a    <= a;
        in_bus.elem_b    <= b;
        in_bus.last_elem <= last;
        do begin
            @(posedge i_clk);
        end while (in_bus.ready !== 1'b1);
        sb.note_pair(a, b, last);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [ELEM_BITS-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            3:       return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // Send one vector pair of the given length; the shape of its content is
    // picked at random so that results spread over the whole range.
    task automatic send_vector(input int len);
        vector_shape_e               shape;
        logic signed [ELEM_BITS-1:0] a;
        logic signed [ELEM_BITS-1:0] b;
        bit                          zero_side_a;
        shape       = vector_shape_e'($urandom_range(SHAPE_RANDOM, SHAPE_TINY));
        zero_side_a = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_RANDOM: begin
                    a = ELEM_BITS'($urandom);
                    b = ELEM_BITS'($urandom);
                end
                SHAPE_PARALLEL: begin
                    a = ELEM_BITS'($urandom);
                    b = a;
                end
                SHAPE_OPPOSED: begin
                    a = ELEM_BITS'($urandom);
                    b = -a;
                end
                SHAPE_NEAR: begin
                    a = ELEM_BITS'($urandom);
                    b = ELEM_BITS'(a + $urandom_range(0, 64) - 32);
                end
                SHAPE_EXTREME: begin
                    a = extreme_value();
                    b = extreme_value();
                end
                SHAPE_ONE_ZERO: begin
                    a = zero_side_a ? '0 : ELEM_BITS'($urandom);
                    b = zero_side_a ? ELEM_BITS'($urandom) : '0;
                end
                default: begin
                    a = ELEM_BITS'($urandom_range(0, 8) - 4);
                    b = ELEM_BITS'($urandom_range(0, 8) - 4);
                end
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // Short vectors of random length until the pair budget is spent.
    task automatic random_phase(input int pair_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < pair_budget) begin
            len = $urandom_range(1, 16);
            send_vector(len);
            sent += len;
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the threshold for one cycle; only called while the block is idle.
    task automatic write_threshold(input logic signed [csu_pkg::SIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        sb.threshold = int'(value);
        settings_used++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic signed [csu_pkg::SIM_W-1:0] thresholds [5];

        in_bus.valid     = 1'b0;
        in_bus.elem_a    = '0;
        in_bus.elem_b    = '0;
        in_bus.last_elem = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        hold_request     = 1'b0;
        pairs_sent       = 0;
        settings_used    = 1;

        thresholds[0] = 16'sh8000;
        thresholds[1] = 16'sh7fff;
        thresholds[2] = 16'sd0;
        thresholds[3] = 16'($urandom);
        thresholds[4] = 16'sd32000;

        // Hold reset, then release it at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, under the reset threshold.
        // Identical full-scale vectors: +1.0 clamps to 32767.
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        // Exactly anti-parallel: -1.0 comes out as -32768.
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        // Zero norm on one side or both.
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sh8000, 1'b1);
        send_pair(16'sd12345, 16'sd0, 1'b1);
        // Orthogonal vectors: zero similarity without the zero-norm flag.
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b1);
        // Mixed content, and leading zero pairs before the real data.
        send_pair(16'sd20000, -16'sd19999, 1'b0);
        send_pair(-16'sd300, 16'sd7, 1'b0);
        send_pair(16'sd21845, -16'sd21846, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd9, 16'sd9, 1'b1);
        // Scaled copy: parallel, so it clamps.
        send_pair(16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd2, 16'sd4, 1'b1);

        // Length limit: the count fills up exactly, then two pairs are
        // dropped, the closing one among them.
        send_vector(MAX_LEN + 2);

        // Random phases, one threshold each; the receiver holds off once
        // so that results back up and the input stalls.
        for (int p = 0; p < 5; p++) begin
            drain();
            write_threshold(thresholds[p]);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            random_phase(150);
        end

        // Final stretch with no idling on either side.
        drain();
        calm = 1'b1;
        write_threshold(16'($urandom_range(28000, 32767)));
        random_phase(200);
        drain();

        $display("Covered %0d element pairs in %0d vectors under %0d threshold settings,",
                 pairs_sent, sb.vectors, settings_used);
        $display("checked %0d results: %0d matches, %0d zero-norm, %0d over-length",
                 sb.checked, sb.matches_seen, sb.zero_seen, sb.long_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/csu_pkg.sv
design/csu_if.sv
design/csu_ratio_core.sv
design/cosine_similarity_unit.sv
tb/cosine_similarity_unit_test.sv
